@@ rtl/iat_pkg.sv @@
package iat_pkg;

  // Token kinds as they appear on the result channel.
  localparam logic [2:0] K_INDENT  = 3'd0;
  localparam logic [2:0] K_DEDENT  = 3'd1;
  localparam logic [2:0] K_NEWLINE = 3'd2;
  localparam logic [2:0] K_WORD    = 3'd3;
  localparam logic [2:0] K_NUMBER  = 3'd4;
  localparam logic [2:0] K_STRING  = 3'd5;
  localparam logic [2:0] K_SYMBOL  = 3'd6;

  // Bytes with a fixed meaning in the scanner.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Default parameter values.
  localparam int POS_BITS_DEF    = 16;
  localparam int DELIM_SLOTS_DEF = 4;

  // Reset value of both delimiter registers: a double quote in slot zero.
  localparam logic [31:0] DELIM_RESET = 32'h0000_0022;

  // Configuration register indexes.
  localparam logic REG_OPEN  = 1'b0;
  localparam logic REG_CLOSE = 1'b1;

  // Token queue between the scanner and the output side.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line_no;
  } tok_t;

  // Everything one source byte produces: one or two tokens.
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } pair_t;

  function automatic tok_t make_tok(input logic [2:0] kind, input logic [15:0] s,
                                    input logic [15:0] e, input logic [15:0] line);
    tok_t t;
    t.kind      = kind;
    t.start_pos = s;
    t.end_pos   = e;
    t.line_no   = line;
    return t;
  endfunction

endpackage

@@ rtl/iat_ifs.sv @@
interface iat_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source(output valid, output ch, output end_of_source, input ready);
  modport sink(input valid, input ch, input end_of_source, output ready);
endinterface

interface iat_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] end_pos;
  logic [15:0] line_no;
  logic        last_of_run;

  modport source(output valid, output token_kind, output start_pos, output end_pos,
                 output line_no, output last_of_run, input ready);
  modport sink(input valid, input token_kind, input start_pos, input end_pos,
               input line_no, input last_of_run, output ready);
endinterface

@@ rtl/iat_regs.sv @@
module iat_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] open_bytes,
  output logic [31:0] close_bytes
);
  import iat_pkg::*;

  logic [31:0] open_r;
  logic [31:0] close_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= DELIM_RESET;
      close_r <= DELIM_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_OPEN) begin
        open_r <= pwdata;
      end else begin
        close_r <= pwdata;
      end
    end
  end

  assign prdata      = (paddr[2] == REG_CLOSE) ? close_r : open_r;
  assign open_bytes  = open_r;
  assign close_bytes = close_r;

endmodule

@@ rtl/iat_front.sv @@
module iat_front #(
  parameter int POS_BITS    = iat_pkg::POS_BITS_DEF,
  parameter int DELIM_SLOTS = iat_pkg::DELIM_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      ch,
  input  logic            eos,
  input  logic            q_ready,
  input  logic [31:0]     open_bytes,
  input  logic [31:0]     close_bytes,
  output logic            push,
  output iat_pkg::pair_t  push_data
);
  import iat_pkg::*;

  localparam logic [2:0] MODE_LINE = 3'd0;
  localparam logic [2:0] MODE_IDLE = 3'd1;
  localparam logic [2:0] MODE_WORD = 3'd2;
  localparam logic [2:0] MODE_NUM  = 3'd3;
  localparam logic [2:0] MODE_STR  = 3'd4;

  localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

  logic [2:0]          mode_r,   mode_nxt;
  logic [POS_BITS-1:0] pos_r,    pos_nxt;
  logic [POS_BITS-1:0] tbeg_r,   tbeg_nxt;
  logic [15:0]         line_r,   line_nxt;
  logic [15:0]         indent_r, indent_nxt;
  logic [15:0]         lead_r,   lead_nxt;
  logic [7:0]          closer_r, closer_nxt;
  logic [15:0]         prev_r,   prev_nxt;

  logic                fire;
  logic [POS_BITS-1:0] nxt;
  logic [15:0]         pos16;
  logic [15:0]         nxt16;
  logic                is_dig;
  logic                is_alp;
  logic                escaped;
  logic                hit;
  logic [7:0]          hit_close;
  logic                start;
  logic                a_v, b_v, c_v;
  tok_t                a_tok, b_tok, c_tok;

  assign fire    = in_valid && q_ready;
  assign nxt     = (pos_r == {POS_BITS{1'b1}}) ? pos_r : pos_r + POS_ONE;
  assign pos16   = 16'(pos_r);
  assign nxt16   = 16'(nxt);
  assign is_dig  = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_alp  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  assign escaped = (prev_r[7:0] == CH_BSLASH) && (prev_r[15:8] != CH_BSLASH);

  // Opening delimiter match; the lowest matching slot wins.
  always_comb begin
    hit       = 1'b0;
    hit_close = '0;
    for (int i = DELIM_SLOTS - 1; i >= 0; i--) begin
      if (open_bytes[8*i +: 8] != 8'h00 && open_bytes[8*i +: 8] == ch) begin
        hit       = 1'b1;
        hit_close = close_bytes[8*i +: 8];
      end
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tbeg_nxt   = tbeg_r;
    line_nxt   = line_r;
    indent_nxt = indent_r;
    lead_nxt   = lead_r;
    closer_nxt = closer_r;
    prev_nxt   = prev_r;
    start      = 1'b0;
    a_v        = 1'b0;
    b_v        = 1'b0;
    c_v        = 1'b0;
    a_tok      = '0;
    b_tok      = '0;
    c_tok      = '0;

    // Token that the current byte closes, or the indent change it reveals.
    unique case (mode_r)
      MODE_LINE: begin
        if (ch == CH_SP) begin
          if (lead_r != 16'hFFFF) lead_nxt = lead_r + 16'd1;
        end else begin
          if (ch != CH_NL && lead_r != indent_r) begin
            a_v        = 1'b1;
            a_tok      = make_tok((lead_r > indent_r) ? K_INDENT : K_DEDENT,
                                  pos16, pos16, line_r);
            indent_nxt = lead_r;
          end
          mode_nxt = MODE_IDLE;
          start    = 1'b1;
        end
      end
      MODE_WORD: begin
        if (!(is_alp || is_dig)) begin
          a_v      = 1'b1;
          a_tok    = make_tok(K_WORD, 16'(tbeg_r), pos16, line_r);
          mode_nxt = MODE_IDLE;
          start    = 1'b1;
        end
      end
      MODE_NUM: begin
        if (!is_dig) begin
          a_v      = 1'b1;
          a_tok    = make_tok(K_NUMBER, 16'(tbeg_r), pos16, line_r);
          mode_nxt = MODE_IDLE;
          start    = 1'b1;
        end
      end
      MODE_STR: begin
        if (ch == CH_NL) begin
          a_v      = 1'b1;
          a_tok    = make_tok(K_STRING, 16'(tbeg_r), pos16, line_r);
          if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
          mode_nxt = MODE_LINE;
          lead_nxt = '0;
        end else if (ch == closer_r && !escaped) begin
          a_v      = 1'b1;
          a_tok    = make_tok(K_STRING, 16'(tbeg_r), pos16, line_r);
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        start    = 1'b1;
      end
    endcase

    // Classification of a byte that begins something new.
    if (start) begin
      if (is_dig) begin
        tbeg_nxt = pos_r;
        mode_nxt = MODE_NUM;
      end else if (is_alp) begin
        tbeg_nxt = pos_r;
        mode_nxt = MODE_WORD;
      end else if (hit) begin
        closer_nxt = hit_close;
        tbeg_nxt   = nxt;
        mode_nxt   = MODE_STR;
      end else if (ch == CH_NL) begin
        b_v      = 1'b1;
        b_tok    = make_tok(K_NEWLINE, pos16, nxt16, line_r);
        if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        mode_nxt = MODE_LINE;
        lead_nxt = '0;
      end else if (ch != CH_SP && ch != CH_TAB) begin
        b_v   = 1'b1;
        b_tok = make_tok(K_SYMBOL, pos16, nxt16, line_r);
      end
    end

    // The last byte flushes a pending token and returns the scanner to reset.
    if (eos) begin
      if (mode_nxt == MODE_WORD) begin
        c_v   = 1'b1;
        c_tok = make_tok(K_WORD, 16'(tbeg_nxt), nxt16, line_r);
      end else if (mode_nxt == MODE_NUM) begin
        c_v   = 1'b1;
        c_tok = make_tok(K_NUMBER, 16'(tbeg_nxt), nxt16, line_r);
      end else if (mode_nxt == MODE_STR) begin
        c_v   = 1'b1;
        c_tok = make_tok(K_STRING, 16'(tbeg_nxt), nxt16, line_r);
      end
      mode_nxt   = MODE_LINE;
      pos_nxt    = '0;
      tbeg_nxt   = '0;
      line_nxt   = '0;
      indent_nxt = '0;
      lead_nxt   = '0;
      closer_nxt = '0;
      prev_nxt   = '0;
    end else begin
      prev_nxt = {prev_r[7:0], ch};
      pos_nxt  = nxt;
    end
  end

  // At most two of the three sources fire for one byte.
  always_comb begin
    push_data.tok0 = a_v ? a_tok : (b_v ? b_tok : c_tok);
    push_data.tok1 = (a_v && b_v) ? b_tok : c_tok;
    push_data.two  = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
  end

  assign push = fire && (a_v || b_v || c_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LINE;
      pos_r    <= '0;
      tbeg_r   <= '0;
      line_r   <= '0;
      indent_r <= '0;
      lead_r   <= '0;
      closer_r <= '0;
      prev_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tbeg_r   <= tbeg_nxt;
      line_r   <= line_nxt;
      indent_r <= indent_nxt;
      lead_r   <= lead_nxt;
      closer_r <= closer_nxt;
      prev_r   <= prev_nxt;
    end
  end

endmodule

@@ rtl/iat_queue.sv @@
module iat_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  iat_pkg::pair_t wdata,
  output logic           not_full,
  input  logic           pop,
  output logic           not_empty,
  output iat_pkg::pair_t rdata
);
  import iat_pkg::*;

  pair_t               mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wptr_r, wptr_nxt;
  logic [PTR_BITS-1:0] rptr_r, rptr_nxt;
  logic [CNT_BITS-1:0] cnt_r,  cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign not_full  = (cnt_r != CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + PTR_BITS'(1) : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + PTR_BITS'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_BITS'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

@@ rtl/iat_back.sv @@
module iat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  iat_pkg::pair_t head,
  output logic           pop,
  iat_tok_if.source      out_tok
);
  import iat_pkg::*;

  logic sel_r, sel_nxt;
  logic fire;
  logic last;
  tok_t cur;

  assign cur  = sel_r ? head.tok1 : head.tok0;
  assign last = !head.two || sel_r;
  assign fire = out_tok.valid && out_tok.ready;
  assign pop  = fire && last;

  always_comb begin
    sel_nxt = sel_r;
    if (fire) sel_nxt = !last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  assign out_tok.valid       = head_valid;
  assign out_tok.token_kind  = cur.kind;
  assign out_tok.start_pos   = cur.start_pos;
  assign out_tok.end_pos     = cur.end_pos;
  assign out_tok.line_no     = cur.line_no;
  assign out_tok.last_of_run = last;

endmodule

@@ rtl/indent_aware_tokenizer_top.sv @@
// Channel   Dir  Handshake                   Beat contents
// in_byte   in   valid/ready                 ch, end_of_source
// out_tok   out  valid/ready                 token_kind, start_pos, end_pos,
//                                            line_no, last_of_run
// cfg (APB) in   psel/penable, pready=1      delimiter registers at 0x0 and 0x4
//
// The scanner takes one source byte per cycle whenever the token queue has room,
// so a byte is accepted in the same cycle it is offered, and its tokens reach
// out_tok only after they have been written into the queue.
// Each byte makes zero, one or two token beats; the output side sends one beat
// per cycle while out_tok is ready, so a byte with two tokens takes two beats.
// The queue holds four byte results, which lets input and output stall apart.
// Reset is synchronous and active low; it clears scanner state, the queue and
// loads the double quote into slot zero of both delimiter registers.
module indent_aware_tokenizer_top #(
  parameter int POS_BITS    = iat_pkg::POS_BITS_DEF,
  parameter int DELIM_SLOTS = iat_pkg::DELIM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  iat_byte_if.sink    in_byte,
  iat_tok_if.source   out_tok,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import iat_pkg::*;

  logic [31:0] open_bytes;
  logic [31:0] close_bytes;
  logic        push;
  pair_t       push_data;
  logic        q_ready;
  logic        q_valid;
  pair_t       q_head;
  logic        pop;

  // Delimiter registers. The user must change them only while the scanner is quiet; the block does not enforce this.
  iat_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .open_bytes  (open_bytes),
    .close_bytes (close_bytes)
  );

  // Front: classifies each byte against the scan state and builds the
  // tokens it completes as a single queue entry.
  iat_front #(
    .POS_BITS    (POS_BITS),
    .DELIM_SLOTS (DELIM_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_byte.valid),
    .ch          (in_byte.ch),
    .eos         (in_byte.end_of_source),
    .q_ready     (q_ready),
    .open_bytes  (open_bytes),
    .close_bytes (close_bytes),
    .push        (push),
    .push_data   (push_data)
  );

  assign in_byte.ready = q_ready;

  // Queue of per-byte results. Its ready depends only on its own fill level,
  // so there is no combinational path from out_tok.ready to in_byte.ready.
  iat_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (push_data),
    .not_full  (q_ready),
    .pop       (pop),
    .not_empty (q_valid),
    .rdata     (q_head)
  );

  // Back: splits an entry into one or two beats and marks the last one.
  iat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (pop),
    .out_tok    (out_tok)
  );

endmodule
